// ===== design/mat_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-slot alarm timer package
// Shared constants, operation codes and the control/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package mat_pkg;

  // Number of alarm slots in the bank.
  localparam int NUM_SLOTS = 16;

  // Field widths of one item and one result.
  localparam int OP_W      = 2;
  localparam int SLOT_W    = 4;
  localparam int CNT_W     = 32;
  localparam int MASK_W    = 16;

  // Width of the scan index over the slot bank.
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  // Width that holds both a slot field and a slot index.
  localparam int SLOT_EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_SET    = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tick_go;   // start a tick: bump the counter, clear the mask, index 0
    logic slot_wr;   // apply a set or cancel item to its slot
    logic slot_arm;  // the slot write comes from a set item
    logic scan;      // visit the slot under the scan index
  } mat_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last; // scan index points at the last slot
  } mat_sts_t;

endpackage

// ===== design/mat_ctrl.sv =====
// ----------------------------------------------------------------------------
// Multi-slot alarm timer controller
// Accepts items, sequences the slot scan of a tick and raises the result
// strobe after the last slot has been visited.
// ----------------------------------------------------------------------------
module mat_ctrl
  import mat_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [OP_W-1:0] opcode_i,
  input  mat_sts_t        sts_i,
  output mat_cmd_t        cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;
  logic accept;

  assign accept = start_i && (state_q == ST_IDLE);

  // Next state, commands and result strobe.
  always_comb begin
    state_d        = state_q;
    done_d         = 1'b0;
    cmd_o.tick_go  = 1'b0;
    cmd_o.slot_wr  = 1'b0;
    cmd_o.slot_arm = 1'b0;
    cmd_o.scan     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_TICK) begin
            cmd_o.tick_go = 1'b1;
            state_d       = ST_SCAN;
          end else if ((opcode_i == OP_SET) || (opcode_i == OP_CANCEL)) begin
            cmd_o.slot_wr  = 1'b1;
            cmd_o.slot_arm = (opcode_i == OP_SET);
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and strobe registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q == ST_SCAN);
  assign done_o = done_q;

endmodule

// ===== design/mat_datapath.sv =====
// ----------------------------------------------------------------------------
// Multi-slot alarm timer datapath
// Holds the tick counter, the slot bank of armed flags and remaining counts,
// the scan index and the fired mask of the current tick.
// ----------------------------------------------------------------------------
module mat_datapath
  import mat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mat_cmd_t          cmd_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [CNT_W-1:0]  timeout_i,
  output mat_sts_t          sts_o,
  output logic [CNT_W-1:0]  tick_count_o,
  output logic [MASK_W-1:0] fired_mask_o
);

  logic [CNT_W-1:0]     tick_q;
  logic [MASK_W-1:0]    mask_q, mask_d;
  logic [IDX_W-1:0]     idx_q;
  logic [NUM_SLOTS-1:0] armed_q;
  logic [CNT_W-1:0]     rem_q [NUM_SLOTS];

  logic [SLOT_EXT_W-1:0] slot_ext;
  logic                  slot_ok;
  logic [IDX_W-1:0]      wr_idx;
  logic [CNT_W-1:0]      rem_cur;
  logic [CNT_W-1:0]      rem_dec;
  logic                  visit;
  logic                  fire;

  // Decode the addressed slot of a set or cancel item.
  assign slot_ext = SLOT_EXT_W'(slot_i);
  assign slot_ok  = (int'(slot_i) < NUM_SLOTS);
  assign wr_idx   = slot_ext[IDX_W-1:0];

  // Slot under the scan index: decrement and detect expiry.
  assign rem_cur = rem_q[idx_q];
  assign rem_dec = rem_cur - CNT_W'(1);
  assign visit   = cmd_i.scan && armed_q[idx_q];
  assign fire    = visit && (rem_dec == '0);

  assign sts_o.scan_last = (idx_q == IDX_W'(NUM_SLOTS - 1));

  // Fired mask of this tick; slots beyond the mask width are not reported.
  always_comb begin
    mask_d = mask_q;
    if (cmd_i.tick_go) begin
      mask_d = '0;
    end else if (fire) begin
      for (int j = 0; j < MASK_W; j++) begin
        if ((j < NUM_SLOTS) && (int'(idx_q) == j)) begin
          mask_d[j] = 1'b1;
        end
      end
    end
  end

  // Tick counter, scan index, mask and armed flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      mask_q  <= '0;
      idx_q   <= '0;
      armed_q <= '0;
    end else begin
      mask_q <= mask_d;
      if (cmd_i.tick_go) begin
        tick_q <= tick_q + CNT_W'(1);
        idx_q  <= '0;
      end else if (cmd_i.scan && !sts_o.scan_last) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.slot_wr && slot_ok) begin
        armed_q[wr_idx] <= cmd_i.slot_arm && (timeout_i != '0);
      end else if (fire) begin
        armed_q[idx_q] <= 1'b0;
      end
    end
  end

  // Remaining counts: one write per cycle, either the item's slot or the
  // slot under the scan. A cancel, or a set with a zero timeout, stores zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.slot_wr && slot_ok) begin
      rem_q[wr_idx] <= cmd_i.slot_arm ? timeout_i : '0;
    end else if (visit) begin
      rem_q[idx_q] <= rem_dec;
    end
  end

  assign tick_count_o = tick_q;
  assign fired_mask_o = mask_q;

endmodule

// ===== design/multi_slot_alarm_timer.sv =====
// ----------------------------------------------------------------------------
// Multi-slot alarm timer
// Free-running tick counter with a bank of one-shot alarm slots. A tick
// reports the new count and the mask of slots that expired on it.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------
//  item in  | start_i high, busy_o | opcode_i, slot_i, timeout_i
//           | low at the edge      |
//  result   | done_o high for one  | tick_count_o, fired_mask_o
//           | cycle                |
//
// A set or cancel item is applied at the edge that accepts it; busy_o stays
// low and the next item may follow in the next cycle.
// A tick item visits one slot per cycle through the single slot read port:
// busy_o is high for the whole scan, and done_o is high in the cycle after
// the last slot, in which a new item may already be accepted.
// Reset clears the tick counter and all armed flags at once; no clearing pass.
// The receiver cannot stall; a result is shown for exactly one cycle.
//
module multi_slot_alarm_timer
  import mat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [CNT_W-1:0]  timeout_i,
  output logic              done_o,
  output logic [CNT_W-1:0]  tick_count_o,
  output logic [MASK_W-1:0] fired_mask_o
);

  mat_cmd_t cmd;
  mat_sts_t sts;

  // Controller: item acceptance and scan sequencing.
  mat_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  // Datapath: counter, slot bank and fired mask.
  mat_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .slot_i       (slot_i),
    .timeout_i    (timeout_i),
    .sts_o        (sts),
    .tick_count_o (tick_count_o),
    .fired_mask_o (fired_mask_o)
  );

  // A result follows the end of a scan, never inside one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy_o && $past(busy_o)))
    else $error("result strobe outside the end of a scan");

  // The result strobe lasts a single cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // An accepted tick starts a scan and bumps the counter by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (opcode_i == OP_TICK)) |=>
      (busy_o && (tick_count_o == $past(tick_count_o) + CNT_W'(1))))
    else $error("tick item did not start a scan or bump the counter");

  // Set and cancel items leave the tick counter alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (opcode_i != OP_TICK)) |=> $stable(tick_count_o))
    else $error("tick counter changed without a tick item");

endmodule
